[design/arj_pkg.sv]
`default_nettype none
package arj_pkg;

	localparam logic [7:0] MarkA = 8'h60;
	localparam logic [7:0] MarkB = 8'hEA;
	localparam logic [39:0] OfsMax = 40'hFF_FFFF_FFFF;
	localparam logic [31:0] W32Max = 32'hFFFF_FFFF;

	localparam logic [2:0] ST_ENTRY = 3'd0;
	localparam logic [2:0] ST_END = 3'd1;
	localparam logic [2:0] ST_BAD = 3'd2;
	localparam logic [2:0] ST_TRUNC = 3'd3;
	localparam logic [2:0] ST_EOF = 3'd4;

	typedef enum logic [3:0] {
		PH_MARK0, PH_MARK1, PH_SIZE0, PH_SIZE1, PH_BASIC,
		PH_EXT0, PH_EXT1, PH_EXTBODY, PH_SKIP, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] entry_index;
		logic [39:0] entry_offset;
		logic [31:0] header_size;
		logic [31:0] compressed_size;
		logic [31:0] original_size;
		logic [31:0] file_crc;
		logic [7:0]  entry_flags;
		logic [7:0]  method;
		logic [31:0] dos_time;
		logic [7:0]  password_modifier;
		logic        last_result;
	} out_word_t;

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [32:0] b);
		logic [33:0] s;
		s = {2'b0, a} + {1'b0, b};
		return (s > {2'b0, W32Max}) ? W32Max : s[31:0];
	endfunction

	function automatic logic [39:0] sat40(input logic [39:0] a, input logic [39:0] b);
		logic [40:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[40] ? OfsMax : s[39:0];
	endfunction

endpackage
`default_nettype wire

[design/arj_walk.sv]
`default_nettype none
// Walk state machine: consumes one registered byte per cycle while step is high and produces up to
// two result words (entry, then summary) for that byte.
module arj_walk
	import arj_pkg::*;
#(
	parameter int FixedHeaderBytes = 30
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_word_t  in_word,
	output out_word_t      res0,
	output out_word_t      res1,
	output logic [1:0]     res_count
);

	// field bytes live in the first 30 header bytes whatever the minimum size
	localparam int BufDepth = 30;
	localparam int BufAw = $clog2(BufDepth);

	phase_t      phase_q;
	logic [39:0] entry_start_q;
	logic [15:0] basic_size_q;
	logic [7:0]  ext_lo_q;
	logic [31:0] countdown_q;
	logic [31:0] header_len_q;
	logic [31:0] entry_count_q;
	logic        main_done_q;
	logic [16:0] basic_idx_q;
	logic [7:0]  buf_q [BufDepth];

	phase_t      phase_d;
	logic [39:0] entry_start_d;
	logic [15:0] basic_size_d;
	logic [31:0] countdown_d;
	logic [31:0] header_len_d;
	logic [31:0] entry_count_d;
	logic        main_done_d;
	logic [16:0] basic_idx_d;
	logic        do_reset;
	logic        buf_we;

	logic [7:0]  b;
	logic        eof;
	logic [15:0] ext_full;
	logic [15:0] size_full;

	function automatic logic [31:0] buf32(input logic [7:0] a0, input logic [7:0] a1,
		input logic [7:0] a2, input logic [7:0] a3);
		return {a3, a2, a1, a0};
	endfunction

	logic [31:0] csize;
	assign csize = buf32(buf_q[12], buf_q[13], buf_q[14], buf_q[15]);

	always_comb begin
		out_word_t e;
		out_word_t s;
		logic fin;
		logic fin_eof;
		logic summ;
		logic [2:0] summ_st;
		logic [31:0] hl;
		logic [31:0] ecount;
		logic [39:0] estart;

		b = in_word.data_byte;
		eof = in_word.end_of_file;
		ext_full = {b, ext_lo_q};
		size_full = {b, basic_size_q[7:0]};
		phase_d = phase_q;
		entry_start_d = entry_start_q;
		basic_size_d = basic_size_q;
		countdown_d = countdown_q;
		header_len_d = header_len_q;
		entry_count_d = entry_count_q;
		main_done_d = main_done_q;
		basic_idx_d = basic_idx_q;
		do_reset = 1'b0;
		buf_we = 1'b0;
		fin = 1'b0;
		fin_eof = eof;
		summ = 1'b0;
		summ_st = ST_EOF;
		hl = header_len_q;
		e = '0;
		s = '0;
		res_count = 2'd0;

		unique case (phase_q)
			PH_MARK0, PH_MARK1: begin
				if (b != ((phase_q == PH_MARK0) ? MarkA : MarkB)) begin
					summ = 1'b1; summ_st = ST_BAD;
				end else if (eof) begin
					summ = 1'b1; summ_st = ST_TRUNC;
				end else begin
					phase_d = (phase_q == PH_MARK0) ? PH_MARK1 : PH_SIZE0;
				end
			end
			PH_SIZE0: begin
				basic_size_d = {8'd0, b};
				if (eof) begin
					summ = 1'b1; summ_st = ST_TRUNC;
				end else begin
					phase_d = PH_SIZE1;
				end
			end
			PH_SIZE1: begin
				basic_size_d = size_full;
				if (size_full == 16'd0) begin
					summ = 1'b1; summ_st = ST_END;
				end else if (eof) begin
					summ = 1'b1; summ_st = ST_TRUNC;
				end else begin
					countdown_d = {16'd0, size_full} + 32'd4;
					basic_idx_d = '0;
					phase_d = PH_BASIC;
				end
			end
			PH_BASIC: begin
				buf_we = (basic_idx_q < {1'b0, basic_size_q}) &&
					(basic_idx_q < 17'(BufDepth));
				basic_idx_d = basic_idx_q + 17'd1;
				countdown_d = countdown_q - 32'd1;
				if (countdown_d != 32'd0) begin
					if (eof) begin
						summ = 1'b1; summ_st = ST_TRUNC;
					end
				end else if (basic_size_q < 16'(FixedHeaderBytes)) begin
					summ = 1'b1; summ_st = ST_BAD;
				end else begin
					hl = {16'd0, basic_size_q} + 32'd8;
					header_len_d = hl;
					if (eof) fin = 1'b1;
					else phase_d = PH_EXT0;
				end
			end
			PH_EXT0: begin
				if (eof) fin = 1'b1;
				else phase_d = PH_EXT1;
			end
			PH_EXT1: begin
				if (ext_full == 16'd0) begin
					hl = sat32(header_len_q, 33'd2);
					header_len_d = hl;
					fin = 1'b1;
				end else begin
					hl = sat32(header_len_q, {17'd0, ext_full} + 33'd6);
					header_len_d = hl;
					if (eof) fin = 1'b1;
					else begin
						countdown_d = {16'd0, ext_full} + 32'd4;
						phase_d = PH_EXTBODY;
					end
				end
			end
			PH_EXTBODY: begin
				if (countdown_q != 32'd0) countdown_d = countdown_q - 32'd1;
				if (eof) fin = 1'b1;
				else if (countdown_d == 32'd0) phase_d = PH_EXT0;
			end
			PH_SKIP: begin
				if (countdown_q != 32'd0) countdown_d = countdown_q - 32'd1;
				if (eof) begin
					summ = 1'b1; summ_st = ST_EOF;
				end else if (countdown_d == 32'd0) phase_d = PH_MARK0;
			end
			default: begin
				if (eof) do_reset = 1'b1;
			end
		endcase

		ecount = entry_count_q;
		estart = entry_start_q;
		if (fin) begin
			// in EXT states the buffer is complete; in BASIC last byte is beyond 30
			if (!main_done_q) begin
				main_done_d = 1'b1;
				estart = {8'd0, hl};
				entry_start_d = estart;
				if (!fin_eof) phase_d = PH_MARK0;
			end else begin
				e.status = ST_ENTRY;
				e.entry_index = entry_count_q;
				e.entry_offset = entry_start_q;
				e.header_size = hl;
				e.compressed_size = csize;
				e.original_size = buf32(buf_q[16], buf_q[17], buf_q[18], buf_q[19]);
				e.file_crc = buf32(buf_q[20], buf_q[21], buf_q[22], buf_q[23]);
				e.entry_flags = buf_q[4];
				e.method = buf_q[5];
				e.dos_time = buf32(buf_q[8], buf_q[9], buf_q[10], buf_q[11]);
				e.password_modifier = buf_q[7];
				e.last_result = 1'b0;
				res_count = 2'd1;
				ecount = sat32(entry_count_q, 33'd1);
				entry_count_d = ecount;
				estart = sat40(sat40(entry_start_q, {8'd0, hl}), {8'd0, csize});
				entry_start_d = estart;
				if (!fin_eof) begin
					if (csize == 32'd0) phase_d = PH_MARK0;
					else begin
						countdown_d = csize;
						phase_d = PH_SKIP;
					end
				end
			end
			if (fin_eof) begin
				summ = 1'b1; summ_st = ST_EOF;
			end
		end

		if (summ) begin
			s.status = summ_st;
			s.entry_index = ecount;
			s.entry_offset = estart;
			s.last_result = 1'b1;
			if (eof) do_reset = 1'b1;
			else phase_d = PH_DONE;
		end

		res0 = (res_count == 2'd1) ? e : s;
		res1 = s;
		res_count = res_count + {1'b0, summ};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARK0;
			entry_start_q <= '0;
			basic_size_q <= '0;
			ext_lo_q <= '0;
			countdown_q <= '0;
			header_len_q <= '0;
			entry_count_q <= '0;
			main_done_q <= 1'b0;
			basic_idx_q <= '0;
		end else if (step) begin
			if (phase_q == PH_EXT0) ext_lo_q <= b;
			if (do_reset) begin
				phase_q <= PH_MARK0;
				entry_start_q <= '0;
				basic_size_q <= '0;
				countdown_q <= '0;
				header_len_q <= '0;
				entry_count_q <= '0;
				main_done_q <= 1'b0;
				basic_idx_q <= '0;
			end else begin
				phase_q <= phase_d;
				entry_start_q <= entry_start_d;
				basic_size_q <= basic_size_d;
				countdown_q <= countdown_d;
				header_len_q <= header_len_d;
				entry_count_q <= entry_count_d;
				main_done_q <= main_done_d;
				basic_idx_q <= basic_idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && buf_we) buf_q[basic_idx_q[BufAw-1:0]] <= b;
	end

`ifndef ASSERT_OFF
	a_two_needs_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_count == 2'd2) |-> res1.last_result && res0.status == ST_ENTRY)
		else $error("entry pair without summary");
	a_main_once: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_count != 2'd0 && res0.status == ST_ENTRY && !res0.last_result)
		|-> main_done_q)
		else $error("entry before main header");
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_DONE) |-> res_count == 2'd0)
		else $error("result after summary");
`endif

endmodule
`default_nettype wire

[design/arj_out_queue.sv]
`default_nettype none
// Two-entry output queue: takes up to two words per step, drains one per cycle while ready is high.
module arj_out_queue
	import arj_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire logic [1:0] push_count,
	input  wire out_word_t push0,
	input  wire out_word_t push1,
	output logic           empty,
	output logic           valid,
	input  wire logic      ready,
	output out_word_t      data
);

	out_word_t  slot_q [2];
	logic [1:0] cnt_q;
	logic       pop;

	assign valid = cnt_q != 2'd0;
	assign empty = cnt_q == 2'd0;
	assign data = slot_q[0];
	assign pop = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q - {1'b0, pop} + (push ? push_count : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && push_count != 2'd0 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			slot_q[0] <= push0;
			slot_q[1] <= push1;
		end else begin
			if (pop) slot_q[0] <= slot_q[1];
			if (push && push_count != 2'd0) slot_q[1] <= push0;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue overflow");
`endif

endmodule
`default_nettype wire

[design/arj_entry_header_walker_unit.sv]
`default_nettype none
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_ready   | in_word_t  (data_byte, end_of_file)
// out     | out | out_valid/out_ready | out_word_t (entry record or summary)
// One byte per cycle unless stalled: input register, then walk logic writes a two-word output queue.
// Each byte yields 0..2 words; the entry and summary on one byte drain one after the other.
// A byte with no words passes at once; one that makes words waits for an empty queue.
// arst_n clears phase, counters and queue; header field bytes are not reset.
module arj_entry_header_walker_unit
	import arj_pkg::*;
#(
	parameter int FIXED_HEADER_BYTES = 30
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	in_word_t   word_s1;
	logic       valid_s1;
	out_word_t  r0;
	out_word_t  r1;
	logic [1:0] rc;
	logic       q_empty;
	logic       step;

	// a byte that makes words needs both slots free
	assign step = valid_s1 && (rc == 2'd0 || q_empty);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) word_s1 <= in_data;
	end

	arj_walk #(.FixedHeaderBytes(FIXED_HEADER_BYTES)) u_walk (
		.clk(clk), .arst_n(arst_n), .step(step), .in_word(word_s1),
		.res0(r0), .res1(r1), .res_count(rc)
	);

	arj_out_queue u_q (
		.clk(clk), .arst_n(arst_n), .push(step), .push_count(rc),
		.push0(r0), .push1(r1), .empty(q_empty),
		.valid(out_valid), .ready(out_ready), .data(out_data)
	);

`ifndef ASSERT_OFF
	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		(step && rc != 2'd0) |-> q_empty)
		else $error("step with occupied queue");
`endif

endmodule
`default_nettype wire
